// ===== sv/rcpd_pkg.sv =====
// Shared types and constants for the RC pulse decoder and arming latch.
// No dependencies; imported by every module of the block.
package rcpd_pkg;

   // Default channel count for the top-level parameter
   localparam int NumChannelsDef = 6;

   // Field widths fixed by the item format
   localparam int ChanW  = 3;
   localparam int TimeW  = 16;
   localparam int WidthW = 16;
   localparam int CsrIdxW = 3;

   // Register reset values
   localparam logic [15:0] TimerPeriodRst    = 16'd20000;
   localparam logic [15:0] ThrottleCutoffRst = 16'd1152;
   localparam logic [15:0] ThrottleTopRst    = 16'd1984;
   localparam logic [15:0] RollCenterRst     = 16'd1416;
   localparam logic [15:0] PitchCenterRst    = 16'd1632;
   localparam logic [15:0] ArmThresholdRst   = 16'd1500;
   localparam logic [15:0] GainOffsetRst     = 16'd1000;

   typedef enum logic [CsrIdxW-1:0] {
      REG_TIMER_PERIOD    = 3'd0,
      REG_THROTTLE_CUTOFF = 3'd1,
      REG_THROTTLE_TOP    = 3'd2,
      REG_ROLL_CENTER     = 3'd3,
      REG_PITCH_CENTER    = 3'd4,
      REG_ARM_THRESHOLD   = 3'd5,
      REG_GAIN_OFFSET     = 3'd6
   } reg_idx_type;

   typedef enum logic {
      OP_CAPTURE  = 1'b0,
      OP_EVALUATE = 1'b1
   } op_type;

   typedef struct packed {
      logic [15:0] timer_period;
      logic [15:0] throttle_cutoff;
      logic [15:0] throttle_top;
      logic [15:0] roll_center;
      logic [15:0] pitch_center;
      logic [15:0] arm_threshold;
      logic [15:0] gain_offset;
   } cfg_type;

   typedef struct packed {
      op_type           op;
      logic [ChanW-1:0] channel;
      logic [TimeW-1:0] capture_time;
   } item_type;

   typedef struct packed {
      logic signed [15:0] throttle;
      logic [15:0]        yaw;
      logic signed [4:0]  roll;
      logic signed [4:0]  pitch;
      logic [15:0]        aux_switch;
      logic [8:0]         armed_marker;
      logic [15:0]        aux_knob;
      logic signed [16:0] gain_hundredths;
      logic               armed;
   } result_type;

endpackage

// ===== sv/rcpd_csr.sv =====
// Configuration register file of the RC pulse decoder.
// Depends on rcpd_pkg for the register index codes and the cfg_type bundle.
module rcpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rcpd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [15:0]                    csr_data,
   output rcpd_pkg::cfg_type              cfg
);
   import rcpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TIMER_PERIOD:    cfg_in.timer_period    = csr_data;
            REG_THROTTLE_CUTOFF: cfg_in.throttle_cutoff = csr_data;
            REG_THROTTLE_TOP:    cfg_in.throttle_top    = csr_data;
            REG_ROLL_CENTER:     cfg_in.roll_center     = csr_data;
            REG_PITCH_CENTER:    cfg_in.pitch_center    = csr_data;
            REG_ARM_THRESHOLD:   cfg_in.arm_threshold   = csr_data;
            REG_GAIN_OFFSET:     cfg_in.gain_offset     = csr_data;
            default:             cfg_in = cfg_ff;  // unmapped index: drop
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_period    <= TimerPeriodRst;
         cfg_ff.throttle_cutoff <= ThrottleCutoffRst;
         cfg_ff.throttle_top    <= ThrottleTopRst;
         cfg_ff.roll_center     <= RollCenterRst;
         cfg_ff.pitch_center    <= PitchCenterRst;
         cfg_ff.arm_threshold   <= ArmThresholdRst;
         cfg_ff.gain_offset     <= GainOffsetRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/rcpd_capture.sv =====
// Edge capture and pulse width store, one entry per channel.
// Depends on rcpd_pkg for item_type and cfg_type.
module rcpd_capture #(
   parameter int NUM_CHANNELS = rcpd_pkg::NumChannelsDef
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       commit,
   input  rcpd_pkg::item_type                         item,
   input  rcpd_pkg::cfg_type                          cfg,
   output logic [NUM_CHANNELS-1:0][rcpd_pkg::WidthW-1:0] widths
);
   import rcpd_pkg::*;

   localparam int ChanBits = $clog2(NUM_CHANNELS);
   localparam logic [ChanW:0] NumCh = (ChanW + 1)'(NUM_CHANNELS);

   logic [NUM_CHANNELS-1:0]             pending_ff, pending_in;
   logic [NUM_CHANNELS-1:0][TimeW-1:0]  rise_ff, rise_in;
   logic [NUM_CHANNELS-1:0][WidthW-1:0] width_ff, width_in;

   logic                chan_ok;
   logic [ChanBits-1:0] idx;
   logic [TimeW-1:0]    rise;
   logic [WidthW-1:0]   pulse;

   assign chan_ok = {1'b0, item.channel} < NumCh;
   assign idx     = item.channel[ChanBits-1:0];
   assign rise    = rise_ff[idx];

   // Fall before rise means the timer wrapped at its period
   assign pulse = (item.capture_time < rise)
                ? WidthW'(cfg.timer_period - rise + item.capture_time)
                : WidthW'(item.capture_time - rise);

   always_comb begin
      pending_in = pending_ff;
      rise_in    = rise_ff;
      width_in   = width_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (commit && chan_ok && (idx == ChanBits'(i))) begin
            if (!pending_ff[i]) begin
               rise_in[i]    = item.capture_time;
               pending_in[i] = 1'b1;
            end else begin
               width_in[i]   = pulse;
               pending_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         rise_ff    <= '0;
         width_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         rise_ff    <= rise_in;
         width_ff   <= width_in;
      end
   end

   assign widths = width_ff;

endmodule

// ===== sv/rcpd_eval.sv =====
// Command evaluation: throttle, axes, aux hold registers and arming latch.
// Depends on rcpd_pkg for cfg_type and result_type.
module rcpd_eval #(
   parameter int NUM_CHANNELS = rcpd_pkg::NumChannelsDef
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          commit,
   input  logic [NUM_CHANNELS-1:0][rcpd_pkg::WidthW-1:0] widths,
   input  rcpd_pkg::cfg_type                             cfg,
   output rcpd_pkg::result_type                          result
);
   import rcpd_pkg::*;

   localparam int          AxisDiv   = 30;
   localparam int          AxisLimit = 10;
   localparam int          AxisSat   = AxisDiv * (AxisLimit + 1);
   // ceil(2^16 / 30); exact for magnitudes below AxisSat
   localparam int          AxisRecip = (65536 + AxisDiv - 1) / AxisDiv;
   localparam logic [8:0]  MarkerVal = 9'd500;

   // (w - c) / 30 toward zero, clamped to +-10
   function automatic logic signed [4:0] axis_cmd(input logic [15:0] w,
                                                  input logic [15:0] c);
      logic signed [16:0] d;
      logic [16:0]        mag;
      logic [20:0]        prod;
      logic [3:0]         q;
      d    = signed'({1'b0, w}) - signed'({1'b0, c});
      mag  = d[16] ? 17'(-d) : 17'(d);
      prod = 21'(mag[8:0]) * 21'(AxisRecip);
      q    = (mag >= 17'(AxisSat)) ? 4'(AxisLimit) : prod[19:16];
      return d[16] ? -signed'({1'b0, q}) : signed'({1'b0, q});
   endfunction

   logic [15:0]        w_throttle, w_yaw, w_switch, w_knob, w_roll, w_pitch;
   logic               below;
   logic signed [16:0] thr_diff, thr_half;
   logic               sw_gt, sw_lt;

   logic               armed_ff, armed_in;
   logic               ready_ff, ready_in;
   logic [15:0]        held_switch_ff, held_switch_in;
   logic [8:0]         held_marker_ff, held_marker_in;
   logic [15:0]        held_knob_ff, held_knob_in;
   logic signed [16:0] held_gain_ff, held_gain_in;

   assign w_throttle = widths[0];
   assign w_yaw      = widths[1];
   assign w_switch   = widths[2];
   assign w_knob     = widths[3];
   assign w_roll     = widths[4];
   assign w_pitch    = widths[5];

   assign below = w_throttle < cfg.throttle_cutoff;
   assign sw_gt = w_switch > cfg.arm_threshold;
   assign sw_lt = w_switch < cfg.arm_threshold;

   // Halve toward zero: bias negatives by one before the arithmetic shift
   assign thr_diff = signed'({1'b0, cfg.throttle_top}) - signed'({1'b0, w_throttle});
   assign thr_half = (thr_diff + signed'({16'b0, thr_diff[16]})) >>> 1;

   always_comb begin
      held_switch_in = held_switch_ff;
      held_marker_in = held_marker_ff;
      held_knob_in   = held_knob_ff;
      held_gain_in   = held_gain_ff;
      armed_in       = armed_ff;
      ready_in       = ready_ff;
      if (below) begin
         armed_in = 1'b0;
      end else begin
         held_switch_in = w_switch;
         held_marker_in = armed_ff ? MarkerVal : 9'd0;
         held_knob_in   = w_knob;
         held_gain_in   = signed'({1'b0, w_knob}) - signed'({1'b0, cfg.gain_offset});
         if (ready_ff && sw_gt) begin
            armed_in = 1'b1;
            ready_in = 1'b0;
         end
         if (sw_lt) begin
            armed_in = 1'b0;
            ready_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.throttle        = below ? 16'sd0 : thr_half[15:0];
      result.yaw             = below ? 16'd0  : w_yaw;
      result.roll            = below ? 5'sd0  : axis_cmd(w_roll, cfg.roll_center);
      result.pitch           = below ? 5'sd0  : axis_cmd(w_pitch, cfg.pitch_center);
      result.aux_switch      = held_switch_in;
      result.armed_marker    = held_marker_in;
      result.aux_knob        = held_knob_in;
      result.gain_hundredths = held_gain_in;
      result.armed           = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         ready_ff       <= 1'b0;
         held_switch_ff <= '0;
         held_marker_ff <= '0;
         held_knob_ff   <= '0;
         held_gain_ff   <= '0;
      end else if (commit) begin
         armed_ff       <= armed_in;
         ready_ff       <= ready_in;
         held_switch_ff <= held_switch_in;
         held_marker_ff <= held_marker_in;
         held_knob_ff   <= held_knob_in;
         held_gain_ff   <= held_gain_in;
      end
   end

endmodule

// ===== sv/rc_pwm_decode_and_arm.sv =====
// RC pulse decoder with throttle cutoff and two-flag arming latch.
// Capture items produce no result; evaluates pass the decode and result registers.
// Throughput: one item per cycle, set by the single decode stage feeding the result
// register; an evaluate stalls while that register is full and rsp_tready is low.
// Reset: synchronous, active high; clears widths, edge flags, latch and holds,
// and loads the configuration registers with their defaults.
module rc_pwm_decode_and_arm #(
   parameter int NUM_CHANNELS = rcpd_pkg::NumChannelsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input items
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,  // channel[2:0], capture_time[18:3], pad
   input  logic                         req_tuser,  // op
   // Result items
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // throttle[15:0], yaw[31:16], roll[36:32], pitch[41:37], aux_switch[57:42],
   // armed_marker[66:58], aux_knob[82:67], gain_hundredths[99:83], armed[100], pad
   output logic [103:0]                 rsp_tdata,
   // Configuration writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rcpd_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0]                  csr_data
);
   import rcpd_pkg::*;

   cfg_type cfg;

   // Decode stage: one registered item waiting to be applied to the state
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       s1_fire;
   logic       cap_commit, eval_commit;

   logic [NUM_CHANNELS-1:0][WidthW-1:0] widths;
   result_type result;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   rcpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // A capture always drains; an evaluate needs room in the result register
   assign s1_fire = s1_valid_ff
                 && ((s1_item_ff.op == OP_CAPTURE) || !rsp_valid_ff || rsp_tready);
   assign cap_commit  = s1_fire && (s1_item_ff.op == OP_CAPTURE);
   assign eval_commit = s1_fire && (s1_item_ff.op == OP_EVALUATE);

   assign req_tready  = !s1_valid_ff || s1_fire;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_fire);

   rcpd_capture #(.NUM_CHANNELS(NUM_CHANNELS)) u_capture (
      .clock  (clock),
      .reset  (reset),
      .commit (cap_commit),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .widths (widths)
   );

   rcpd_eval #(.NUM_CHANNELS(NUM_CHANNELS)) u_eval (
      .clock  (clock),
      .reset  (reset),
      .commit (eval_commit),
      .widths (widths),
      .cfg    (cfg),
      .result (result)
   );

   // Hold the result until taken; a new evaluate may load on the same edge
   assign rsp_valid_in = eval_commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.op           <= op_type'(req_tuser);
         s1_item_ff.channel      <= req_tdata[2:0];
         s1_item_ff.capture_time <= req_tdata[18:3];
      end
      if (eval_commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.armed,
                        rsp_data_ff.gain_hundredths,
                        rsp_data_ff.aux_knob,
                        rsp_data_ff.armed_marker,
                        rsp_data_ff.aux_switch,
                        rsp_data_ff.pitch,
                        rsp_data_ff.roll,
                        rsp_data_ff.yaw,
                        rsp_data_ff.throttle};

endmodule
